/* hw/rtl/afsk_pkg.sv */
// Shared types, codes and constants of the AFSK modulator.
`timescale 1ns / 1ps
`default_nettype none

package afsk_pkg;

    // Default sizes of the block.
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int DAC_WIDTH_DEF   = 12;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_WIDTH = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MARK_DELAY  = 2'd0;
    localparam logic [1:0] CFG_SPACE_DELAY = 2'd1;
    localparam logic [1:0] CFG_BIT_PERIOD  = 2'd2;

    // Register reset values.
    localparam logic [CFG_WIDTH-1:0] MARK_DELAY_RST  = 16'd312;
    localparam logic [CFG_WIDTH-1:0] SPACE_DELAY_RST = 16'd170;
    localparam logic [CFG_WIDTH-1:0] BIT_PERIOD_RST  = 16'd20000;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [2:0] STUFF_LIMIT = 3'd5;
    localparam logic [2:0] ONES_MAX    = 3'd7;
    localparam int         MID_SCALE   = 2048;

    localparam int SINE_DEPTH = 64;
    localparam int SINE_BITS  = 12;

    // One period of the sine wave, 12-bit unsigned samples.
    localparam logic [SINE_BITS-1:0] SINE_ROM [SINE_DEPTH] = '{
        12'd2248, 12'd2447, 12'd2642, 12'd2831, 12'd3013, 12'd3185, 12'd3347, 12'd3496,
        12'd3631, 12'd3750, 12'd3854, 12'd3940, 12'd4007, 12'd4056, 12'd4086, 12'd4094,
        12'd4086, 12'd4056, 12'd4007, 12'd3940, 12'd3854, 12'd3750, 12'd3631, 12'd3496,
        12'd3347, 12'd3185, 12'd3013, 12'd2831, 12'd2642, 12'd2447, 12'd2248, 12'd2048,
        12'd1847, 12'd1648, 12'd1453, 12'd1264, 12'd1082, 12'd910,  12'd748,  12'd599,
        12'd464,  12'd345,  12'd241,  12'd155,  12'd88,   12'd39,   12'd9,    12'd0,
        12'd9,    12'd39,   12'd88,   12'd155,  12'd241,  12'd345,  12'd464,  12'd599,
        12'd748,  12'd910,  12'd1082, 12'd1264, 12'd1453, 12'd1648, 12'd1847, 12'd2048
    };

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_BYTE  = 2'd2
    } req_e_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] mark_delay;
        logic [CFG_WIDTH-1:0] space_delay;
        logic [CFG_WIDTH-1:0] bit_period;
    } cfg_t;

    typedef struct packed {
        logic dac_update;
        logic byte_request;
        logic busy_res;
        logic underrun;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/afsk_cfg_regs.sv */
// Configuration registers: tone sample delays and bit period.
`timescale 1ns / 1ps
`default_nettype none

module afsk_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [afsk_pkg::CFG_WIDTH-1:0] cfg_wdata,
    output afsk_pkg::cfg_t                      cfg
);
    import afsk_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MARK_DELAY:  cfg_next.mark_delay  = cfg_wdata;
                CFG_SPACE_DELAY: cfg_next.space_delay = cfg_wdata;
                CFG_BIT_PERIOD:  cfg_next.bit_period  = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mark_delay  <= MARK_DELAY_RST;
            cfg_reg.space_delay <= SPACE_DELAY_RST;
            cfg_reg.bit_period  <= BIT_PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/afsk_in_stage.sv */
// Input register holding one request word until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module afsk_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic [1:0] s_tuser,
    input  wire logic       s_tlast,
    input  wire logic       advance,
    output logic            item_valid,
    output afsk_pkg::item_t item
);
    import afsk_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  accept;

    assign s_tready   = !valid_reg || advance;
    assign accept     = s_tvalid && s_tready;
    assign valid_next = accept || (valid_reg && !advance);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.req_type  <= s_tuser;
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/afsk_core.sv */
// Modulator state: countdowns, sine phase, NRZI tone, bit stuffing and byte holder.
`timescale 1ns / 1ps
`default_nettype none

module afsk_core #(
    parameter int TABLE_DEPTH = afsk_pkg::TABLE_DEPTH_DEF,
    parameter int DAC_WIDTH   = afsk_pkg::DAC_WIDTH_DEF,
    parameter int COUNT_WIDTH = afsk_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire afsk_pkg::item_t      item,
    input  wire afsk_pkg::cfg_t       cfg,
    output logic [DAC_WIDTH-1:0]      dac_value,
    output afsk_pkg::status_t         status
);
    import afsk_pkg::*;

    localparam int PHASE_W = $clog2(TABLE_DEPTH);
    localparam int SHIFT   = 28 - DAC_WIDTH;

    // Sine samples resampled to the table depth and scaled to the DAC width.
    logic [DAC_WIDTH-1:0] wave [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_wave
        localparam int ROM_IDX = ((g * SINE_DEPTH) / TABLE_DEPTH) % SINE_DEPTH;
        localparam logic [27:0] WIDE = {SINE_ROM[ROM_IDX], 16'h0000};
        assign wave[g] = DAC_WIDTH'(WIDE >> SHIFT);
    end

    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] sample_cd_reg, sample_cd_next;
    logic [COUNT_WIDTH-1:0] bit_cd_reg, bit_cd_next;
    logic                   tone_reg, tone_next;
    logic [7:0]             shift_reg, shift_next;
    logic [2:0]             pos_reg, pos_next;
    logic [2:0]             ones_reg, ones_next;
    logic                   stuff_reg, stuff_next;
    logic [7:0]             held_byte_reg, held_byte_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   held_last_reg, held_last_next;
    logic                   cur_last_reg, cur_last_next;
    logic                   active_reg, active_next;
    logic [DAC_WIDTH-1:0]   dac_reg, dac_next;
    logic                   underrun_reg, underrun_next;
    logic                   spent_reg, spent_next;

    logic                   update;
    logic                   send_bit;
    logic [7:0]             bit_src;
    logic [2:0]             pos_src;
    logic                   stuff_src;
    logic [COUNT_WIDTH-1:0] tone_delay;

    assign tone_delay = tone_reg ? COUNT_WIDTH'(cfg.mark_delay)
                                 : COUNT_WIDTH'(cfg.space_delay);

    always_comb begin
        phase_next      = phase_reg;
        sample_cd_next  = sample_cd_reg;
        bit_cd_next     = bit_cd_reg;
        tone_next       = tone_reg;
        shift_next      = shift_reg;
        pos_next        = pos_reg;
        ones_next       = ones_reg;
        stuff_next      = stuff_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_last_next  = held_last_reg;
        cur_last_next   = cur_last_reg;
        active_next     = active_reg;
        dac_next        = dac_reg;
        underrun_next   = underrun_reg;
        spent_next      = spent_reg;
        update          = 1'b0;
        send_bit        = 1'b0;
        bit_src         = shift_reg;
        pos_src         = pos_reg;
        stuff_src       = stuff_reg;

        case (req_e_t'(item.req_type))
            REQ_START: begin
                active_next    = 1'b1;
                shift_next     = FLAG_BYTE;
                pos_next       = '0;
                ones_next      = '0;
                stuff_next     = 1'b0;
                cur_last_next  = 1'b0;
                spent_next     = 1'b0;
                tone_next      = 1'b0;
                phase_next     = '0;
                sample_cd_next = COUNT_WIDTH'(cfg.space_delay);
                bit_cd_next    = COUNT_WIDTH'(cfg.bit_period);
                underrun_next  = 1'b0;
            end
            REQ_BYTE: begin
                held_byte_next  = item.data_byte;
                held_last_next  = item.last_byte;
                held_valid_next = 1'b1;
            end
            REQ_TICK: begin
                if (active_reg) begin
                    // Sample step uses the tone in force before this tick's bit step.
                    if (sample_cd_reg <= COUNT_WIDTH'(1)) begin
                        dac_next       = wave[phase_reg];
                        phase_next     = (phase_reg == PHASE_W'(TABLE_DEPTH - 1))
                                         ? '0 : phase_reg + 1'b1;
                        sample_cd_next = tone_delay;
                        update         = 1'b1;
                    end else begin
                        sample_cd_next = sample_cd_reg - 1'b1;
                    end

                    if (bit_cd_reg <= COUNT_WIDTH'(1)) begin
                        bit_cd_next = COUNT_WIDTH'(cfg.bit_period);
                        if (stuff_reg && ones_reg >= STUFF_LIMIT) begin
                            // Inserted zero: its own bit period, toggles the tone.
                            tone_next = !tone_reg;
                            ones_next = '0;
                        end else if (spent_reg) begin
                            if (cur_last_reg) begin
                                active_next = 1'b0;
                                spent_next  = 1'b0;
                            end else if (!held_valid_reg) begin
                                active_next   = 1'b0;
                                spent_next    = 1'b0;
                                underrun_next = 1'b1;
                            end else begin
                                shift_next      = held_byte_reg;
                                cur_last_next   = held_last_reg;
                                held_valid_next = 1'b0;
                                stuff_next      = 1'b1;
                                spent_next      = 1'b0;
                                bit_src         = held_byte_reg;
                                pos_src         = '0;
                                stuff_src       = 1'b1;
                                send_bit        = 1'b1;
                            end
                        end else begin
                            send_bit = 1'b1;
                        end

                        if (send_bit) begin
                            if (!bit_src[pos_src]) begin
                                tone_next = !tone_reg;
                                ones_next = '0;
                            end else if (stuff_src && ones_reg < ONES_MAX) begin
                                ones_next = ones_reg + 1'b1;
                            end
                            if (pos_src == 3'd7) begin
                                pos_next   = '0;
                                spent_next = 1'b1;
                            end else begin
                                pos_next = pos_src + 1'b1;
                            end
                        end
                    end else begin
                        bit_cd_next = bit_cd_reg - 1'b1;
                    end
                end
            end
            default: begin
                update = 1'b0;
            end
        endcase
    end

    assign dac_value           = dac_next;
    assign status.dac_update   = update;
    assign status.byte_request = active_next && !held_valid_next && !cur_last_next;
    assign status.busy_res     = active_next;
    assign status.underrun     = underrun_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            sample_cd_reg  <= '0;
            bit_cd_reg     <= '0;
            tone_reg       <= 1'b0;
            shift_reg      <= '0;
            pos_reg        <= '0;
            ones_reg       <= '0;
            stuff_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            held_last_reg  <= 1'b0;
            cur_last_reg   <= 1'b0;
            active_reg     <= 1'b0;
            dac_reg        <= DAC_WIDTH'(MID_SCALE);
            underrun_reg   <= 1'b0;
            spent_reg      <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            sample_cd_reg  <= sample_cd_next;
            bit_cd_reg     <= bit_cd_next;
            tone_reg       <= tone_next;
            shift_reg      <= shift_next;
            pos_reg        <= pos_next;
            ones_reg       <= ones_next;
            stuff_reg      <= stuff_next;
            held_valid_reg <= held_valid_next;
            held_last_reg  <= held_last_next;
            cur_last_reg   <= cur_last_next;
            active_reg     <= active_next;
            dac_reg        <= dac_next;
            underrun_reg   <= underrun_next;
            spent_reg      <= spent_next;
        end
    end

    // The holder byte has no defined value until a byte word arrives.
    always_ff @(posedge aclk) begin
        if (step) begin
            held_byte_reg <= held_byte_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/afsk_out_stage.sv */
// Result register that packs the sample and status flags into one output word.
`timescale 1ns / 1ps
`default_nettype none

module afsk_out_stage #(
    parameter int DAC_WIDTH = afsk_pkg::DAC_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                load,
    input  wire logic [DAC_WIDTH-1:0]                dac_value,
    input  wire afsk_pkg::status_t                   status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((DAC_WIDTH + 4 + 7) / 8) * 8-1:0] m_tdata
);
    import afsk_pkg::*;

    localparam int TDATA_W = ((DAC_WIDTH + 4 + 7) / 8) * 8;

    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg;

    assign valid_next = load || (valid_reg && !m_tready);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= TDATA_W'({status.underrun, status.busy_res, status.byte_request,
                                  status.dac_update, dac_value});
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/afsk_nrzi_bitstuff_modulator.sv */
// AFSK modulator with NRZI coding and bit stuffing: top level.
// A word accepted into the input register goes through the core into the result register on m_tdata.
// Throughput: one word per cycle; the state update for a word is done combinationally
// between the input register and the result register, and a low m_tready holds both.
// Reset: synchronous, active low on aresetn; clears the handshake, the frame
// state and the registers to their defaults, with the DAC sample at mid scale.
`timescale 1ns / 1ps
`default_nettype none

module afsk_nrzi_bitstuff_modulator #(
    parameter int TABLE_DEPTH = afsk_pkg::TABLE_DEPTH_DEF,
    parameter int DAC_WIDTH   = afsk_pkg::DAC_WIDTH_DEF,
    parameter int COUNT_WIDTH = afsk_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // data_byte
    input  wire logic [1:0]                          s_tuser,  // req_type
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // dac_value, dac_update, byte_request, busy_res, underrun, zero fill
    output logic [((DAC_WIDTH + 4 + 7) / 8) * 8-1:0] m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [afsk_pkg::CFG_WIDTH-1:0]      cfg_wdata
);
    import afsk_pkg::*;

    cfg_t                 cfg;
    item_t                item;
    status_t              status;
    logic                 item_valid;
    logic                 advance;
    logic [DAC_WIDTH-1:0] dac_value;

    // A word moves on when the result register is empty or being drained.
    assign advance = item_valid && (!m_tvalid || m_tready);

    afsk_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    afsk_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    afsk_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DAC_WIDTH   (DAC_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (item),
        .cfg       (cfg),
        .dac_value (dac_value),
        .status    (status)
    );

    afsk_out_stage #(
        .DAC_WIDTH (DAC_WIDTH)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .dac_value (dac_value),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Every word taken by the core shows up in the result register next cycle.
    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed word did not reach the result register");

    // Input side stalls only while a word waits in the input register.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> item_valid)
        else $error("input stalled with an empty input register");

    // A frame in progress never reports an underrun.
    a_busy_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[DAC_WIDTH + 2] && m_tdata[DAC_WIDTH + 3]))
        else $error("busy and underrun reported together");

    // A byte is only requested while a frame is being sent.
    a_request_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DAC_WIDTH + 1] |-> m_tdata[DAC_WIDTH + 2])
        else $error("byte request outside of a frame");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the AFSK modulator with NRZI coding and bit stuffing.
`timescale 1ns / 1ps

module tb;
    import afsk_pkg::*;

    localparam int         PIPE_LATENCY = 2;
    localparam logic [1:0] REQ_NONE     = 2'd3;  // unused request code, ignored by the block

    // Output word as it sits in m_tdata, highest field first.
    typedef struct packed {
        logic        underrun;
        logic        busy_res;
        logic        byte_request;
        logic        dac_update;
        logic [11:0] dac_value;
    } afsk_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // data_byte
    logic [1:0]  s_tuser = '0;   // req_type
    logic        s_tlast = 1'b0; // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // dac_value, dac_update, byte_request, busy_res, underrun
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    afsk_nrzi_bitstuff_modulator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Modulator state as the testbench tracks it.
    logic [15:0] mark_dly, space_dly, bit_len;
    logic [5:0]  phase;
    logic [15:0] samp_cnt, bit_cnt;
    logic        tone_mark;
    logic [7:0]  shreg, hold_byte;
    logic [2:0]  bitpos, ones;
    logic        stuff_en, hold_full, hold_last, cur_last, in_frame, starved, spent;
    logic [11:0] dac;

    afsk_word_t dac_words_due[$];
    afsk_word_t want, got;
    bit         failed = 1'b0;
    bit         calm = 1'b0;
    int         items_sent = 0;
    int         item_cap = 0;
    int         stall_left = 0;

    function automatic void reset_modulator();
        mark_dly  = MARK_DELAY_RST;
        space_dly = SPACE_DELAY_RST;
        bit_len   = BIT_PERIOD_RST;
        phase     = '0;
        samp_cnt  = '0;
        bit_cnt   = '0;
        tone_mark = 1'b0;
        shreg     = '0;
        hold_byte = '0;
        bitpos    = '0;
        ones      = '0;
        stuff_en  = 1'b0;
        hold_full = 1'b0;
        hold_last = 1'b0;
        cur_last  = 1'b0;
        in_frame  = 1'b0;
        starved   = 1'b0;
        spent     = 1'b0;
        dac       = 12'(MID_SCALE);
    endfunction

    function automatic logic [15:0] tone_delay();
        return tone_mark ? mark_dly : space_dly;
    endfunction

    // One bit boundary: a pending stuffed zero, else the next data bit, loading
    // the held byte or ending the frame once the current byte is used up.
    function automatic void advance_bit();
        logic b;
        if (stuff_en && ones >= STUFF_LIMIT) begin
            tone_mark = !tone_mark;
            ones = '0;
            return;
        end
        if (spent) begin
            if (cur_last || !hold_full) begin
                starved  = starved | !cur_last;
                in_frame = 1'b0;
                spent    = 1'b0;
                return;
            end
            shreg     = hold_byte;
            cur_last  = hold_last;
            hold_full = 1'b0;
            stuff_en  = 1'b1;
            bitpos    = '0;
            spent     = 1'b0;
        end
        b = shreg[bitpos];
        if (!b) begin
            tone_mark = !tone_mark;
            ones = '0;
        end else if (stuff_en && ones < ONES_MAX) begin
            ones = ones + 3'd1;
        end
        if (bitpos == 3'd7) begin
            bitpos = '0;
            spent = 1'b1;
        end else begin
            bitpos = bitpos + 3'd1;
        end
    endfunction

    function automatic afsk_word_t modulate(logic [1:0] req, logic [7:0] data, logic last);
        afsk_word_t w;
        w.dac_update = 1'b0;
        case (req)
            REQ_START: begin
                in_frame  = 1'b1;
                shreg     = FLAG_BYTE;
                bitpos    = '0;
                ones      = '0;
                stuff_en  = 1'b0;
                cur_last  = 1'b0;
                spent     = 1'b0;
                tone_mark = 1'b0;
                phase     = '0;
                samp_cnt  = tone_delay();
                bit_cnt   = bit_len;
                starved   = 1'b0;
            end
            REQ_BYTE: begin
                hold_byte = data;
                hold_last = last;
                hold_full = 1'b1;
            end
            REQ_TICK: begin
                if (in_frame) begin
                    // The sample reload uses the tone in force before the bit step.
                    if (samp_cnt <= 16'd1) begin
                        dac = SINE_ROM[phase];
                        phase = phase + 6'd1;
                        samp_cnt = tone_delay();
                        w.dac_update = 1'b1;
                    end else begin
                        samp_cnt = samp_cnt - 16'd1;
                    end
                    if (bit_cnt <= 16'd1) begin
                        bit_cnt = bit_len;
                        advance_bit();
                    end else begin
                        bit_cnt = bit_cnt - 16'd1;
                    end
                end
            end
            default: ;
        endcase
        w.dac_value    = dac;
        w.byte_request = in_frame && !hold_full && !cur_last;
        w.busy_res     = in_frame;
        w.underrun     = starved;
        return w;
    endfunction

    task automatic send_item(input logic [1:0] req, input logic [7:0] data, input logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (req == REQ_START || req == REQ_BYTE || (req == REQ_TICK && in_frame))
            items_sent++;
        dac_words_due.push_back(modulate(req, data, last));
    endtask

    task automatic tick();
        send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Waits until every word in flight has come out and the pipeline is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (dac_words_due.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain();
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MARK_DELAY:  mark_dly  = val;
            CFG_SPACE_DELAY: space_dly = val;
            CFG_BIT_PERIOD:  bit_len   = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_tones(input logic [15:0] mark, input logic [15:0] space,
                             input logic [15:0] period);
        write_reg(CFG_MARK_DELAY, mark);
        write_reg(CFG_SPACE_DELAY, space);
        write_reg(CFG_BIT_PERIOD, period);
    endtask

    // A start, then the frame bytes fed as the holder empties; a starved frame
    // withholds its last byte so that it ends in underrun.
    task automatic send_frame(input int n_bytes, input bit starve);
        int         fed;
        logic [7:0] data;
        fed = starve ? n_bytes - 1 : n_bytes;
        send_item(REQ_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (int i = 0; i < fed; i++) begin
            while (in_frame && hold_full && items_sent < item_cap) tick();
            case ($urandom_range(0, 3))
                0: data = 8'hFF;
                1: data = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
                default: data = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 7) == 0)
                send_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_item(REQ_BYTE, data, i == n_bytes - 1);
        end
        while (in_frame && items_sent < item_cap) tick();
    endtask

    task automatic run_random(input int budget);
        item_cap = items_sent + budget;
        while (items_sent < item_cap) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat (3)
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                end
                1: begin
                    // Restart a frame that is already under way.
                    send_item(REQ_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 6)) tick();
                    send_frame($urandom_range(1, 4), 1'b0);
                end
                default: send_frame($urandom_range(1, 4), $urandom_range(0, 7) == 0);
            endcase
        end
    endtask

    task automatic test_reset_values();
        send_item(REQ_START, 8'h00, 1'b0);
        send_item(REQ_BYTE, 8'h3C, 1'b1);
        repeat (175) tick();
    endtask

    task automatic test_directed();
        set_tones(16'd2, 16'd1, 16'd1);
        send_item(REQ_NONE, 8'hFF, 1'b1);
        tick();
        send_item(REQ_BYTE, 8'hFF, 1'b0);
        send_item(REQ_START, 8'h00, 1'b0);
        repeat (12) tick();
        send_item(REQ_BYTE, 8'h00, 1'b1);
        send_item(REQ_NONE, 8'h00, 1'b0);
        while (in_frame) tick();
        // No byte supplied after the flag: the frame ends in underrun.
        send_item(REQ_START, 8'hFF, 1'b1);
        repeat (9) tick();
        send_item(REQ_BYTE, 8'h55, 1'b0);
        send_item(REQ_BYTE, 8'hAA, 1'b1);
        send_item(REQ_START, 8'h00, 1'b0);
        repeat (3) tick();
        send_item(REQ_START, 8'h00, 1'b0);
        while (in_frame) tick();
    endtask

    task automatic test_register_extremes();
        set_tones(16'hFFFF, 16'd1, 16'hFFFF);
        send_item(REQ_START, 8'h00, 1'b0);
        repeat (30) tick();
        write_reg(CFG_SPACE_DELAY, 16'hFFFF);
        repeat (10) tick();
        write_reg(CFG_MARK_DELAY, 16'd1);
        repeat (5) tick();
    endtask

    task automatic test_random_frames();
        set_tones(16'd1, 16'd1, 16'd1);
        run_random(240);
        set_tones(16'd3, 16'd2, 16'd2);
        run_random(240);
        set_tones(16'd2, 16'd7, 16'd3);
        run_random(240);
        set_tones(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 4)));
        run_random(240);
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        set_tones(16'd4, 16'd2, 16'd2);
        run_random(150);
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (dac_words_due.size() == 0) begin
                $error("unexpected word 0x%04h with nothing pending", m_tdata);
                failed = 1'b1;
            end else begin
                want = dac_words_due.pop_front();
                got  = m_tdata;
                if (got.dac_value !== want.dac_value) begin
                    $error("dac_value: expected %0d, got %0d", want.dac_value, got.dac_value);
                    failed = 1'b1;
                end
                if (got.dac_update !== want.dac_update) begin
                    $error("dac_update: expected %0b, got %0b", want.dac_update, got.dac_update);
                    failed = 1'b1;
                end
                if (got.byte_request !== want.byte_request) begin
                    $error("byte_request: expected %0b, got %0b",
                           want.byte_request, got.byte_request);
                    failed = 1'b1;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
                    failed = 1'b1;
                end
                if (got.underrun !== want.underrun) begin
                    $error("underrun: expected %0b, got %0b", want.underrun, got.underrun);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        reset_modulator();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_directed();
        test_register_extremes();
        test_random_frames();
        test_no_idle();
        drain();
        repeat (8) @(posedge aclk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
